/* rtl/irqc_pkg.sv */
`default_nettype none

package irqc_pkg;

  localparam int DEF_REG_WORDS = 16;
  localparam int OFF_W         = 6;
  localparam int WORD_W        = OFF_W - 2;
  localparam int WORD_SPAN     = 2 ** WORD_W;
  localparam int DATA_W        = 32;
  localparam int WIN_W         = 7;
  localparam int SRC_W         = 4;

  localparam logic [WIN_W-1:0]  WINDOW_RESET = 7'd64;
  localparam logic [DATA_W-1:0] SRC_MASK     = 32'h0000_03FF;
  localparam logic [SRC_W-1:0]  NUM_SOURCES  = 4'd10;
  localparam logic [SRC_W-1:0]  SRC_IRQ_ONLY = 4'd9;

  localparam logic [OFF_W-1:0] OFF_ENABLE  = 6'h08;
  localparam logic [OFF_W-1:0] OFF_DISABLE = 6'h0C;

  localparam int IDX_IRQ_STATUS = 0;
  localparam int IDX_RAW_STATUS = 1;
  localparam int IDX_ENABLE     = 2;
  localparam int IDX_MODE       = 5;
  localparam int IDX_FIQ_STATUS = 6;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RAISE = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_LOWER = 2'd2
  } action_t;

  localparam logic [1:0] LINE_IRQ = 2'd2;
  localparam logic [1:0] LINE_FIQ = 2'd3;

  typedef struct packed {
    func_t             func;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_word;
    logic [SRC_W-1:0]  source_num;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_word;
    action_t           line_action;
    logic [1:0]        cpu_line;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/irq_fiq_interrupt_controller_unit.sv */
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall    in_data   (in_item_t)
// out_      output     out_valid / out_stall  out_data  (out_item_t)
// cfg_      input      cfg_valid / cfg_ready  cfg_window_bytes
//
// One transaction per cycle sustained while the result is not stalled.
// The input register feeds one read-modify-write of the register file into
// the result register.
// Synchronous active-low reset clears all register words and sets the window to 64.
// A stalled result holds the input register; in_stall rises only when both are full.

module irq_fiq_interrupt_controller_unit
  import irqc_pkg::*;
#(
  parameter int REG_WORDS = DEF_REG_WORDS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [WIN_W-1:0] cfg_window_bytes
);

  localparam int DEPTH = (REG_WORDS < WORD_SPAN) ? REG_WORDS : WORD_SPAN;
  localparam int IDX_W = $clog2(DEPTH);

  logic [DATA_W-1:0] regs_r   [DEPTH];
  logic [DATA_W-1:0] regs_nxt [DEPTH];
  logic [WIN_W-1:0]  window_r;
  in_item_t          s0_data_r;
  logic              s0_valid_r;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;
  logic              out_valid_r;

  logic              adv;
  logic              in_take;
  logic [WORD_W-1:0] word;
  logic [IDX_W-1:0]  idx;
  logic              in_window;
  logic [OFF_W-1:0]  aligned;
  logic [DATA_W-1:0] bit_sel;
  logic              src_ok;
  logic [1:0]        route;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s0_valid_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign word      = s0_data_r.reg_offset[OFF_W-1:2];
  assign idx       = IDX_W'(word);
  assign aligned   = {word, 2'b00};
  assign in_window = ({1'b0, s0_data_r.reg_offset} < window_r) && (int'(word) < DEPTH);
  assign src_ok    = s0_data_r.source_num < NUM_SOURCES;
  assign bit_sel   = DATA_W'(1) << s0_data_r.source_num;

  always_comb begin
    if (s0_data_r.source_num == SRC_IRQ_ONLY) begin
      route = LINE_IRQ;
    end else if ((regs_r[IDX_MODE] & bit_sel) != '0) begin
      route = LINE_FIQ;
    end else begin
      route = LINE_IRQ;
    end
  end

  always_comb begin
    regs_nxt                 = regs_r;
    out_data_nxt.read_word   = '0;
    out_data_nxt.line_action = ACT_NONE;
    out_data_nxt.cpu_line    = LINE_IRQ;
    unique case (s0_data_r.func)
      FUNC_READ: begin
        if (in_window) begin
          out_data_nxt.read_word = regs_r[idx];
        end
      end
      FUNC_WRITE: begin
        if (in_window) begin
          priority if (aligned == OFF_ENABLE) begin
            regs_nxt[IDX_ENABLE] = regs_r[IDX_ENABLE] | (s0_data_r.write_word & SRC_MASK);
          end else if (aligned == OFF_DISABLE) begin
            regs_nxt[IDX_ENABLE] = regs_r[IDX_ENABLE] & ~(s0_data_r.write_word & SRC_MASK);
          end else begin
            regs_nxt[idx] = s0_data_r.write_word;
          end
        end
      end
      FUNC_RAISE: begin
        if (src_ok) begin
          regs_nxt[IDX_RAW_STATUS] = regs_r[IDX_RAW_STATUS] | bit_sel;
          if ((regs_r[IDX_ENABLE] & bit_sel) != '0) begin
            if (route == LINE_FIQ) begin
              regs_nxt[IDX_FIQ_STATUS] = regs_r[IDX_FIQ_STATUS] | bit_sel;
            end else begin
              regs_nxt[IDX_IRQ_STATUS] = regs_r[IDX_IRQ_STATUS] | bit_sel;
            end
            out_data_nxt.line_action = ACT_RAISE;
            out_data_nxt.cpu_line    = route;
          end
        end
      end
      FUNC_CLEAR: begin
        if (src_ok) begin
          regs_nxt[IDX_RAW_STATUS] = regs_r[IDX_RAW_STATUS] & ~bit_sel;
          if (route == LINE_FIQ) begin
            regs_nxt[IDX_FIQ_STATUS] = regs_r[IDX_FIQ_STATUS] & ~bit_sel;
          end else begin
            regs_nxt[IDX_IRQ_STATUS] = regs_r[IDX_IRQ_STATUS] & ~bit_sel;
          end
          out_data_nxt.line_action = ACT_LOWER;
          out_data_nxt.cpu_line    = route;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_bytes;
      end
      if (adv) begin
        out_valid_r <= s0_valid_r;
        if (s0_valid_r) begin
          regs_r <= regs_nxt;
        end
      end
      s0_valid_r <= in_take || (s0_valid_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_data_r <= in_data;
    end
    if (adv && s0_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Idle results always name the IRQ line.
  a_idle_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.line_action == ACT_NONE |-> out_data_r.cpu_line == LINE_IRQ)
    else $error("idle result names a line other than IRQ");

  a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.read_word != '0 |-> out_data_r.line_action == ACT_NONE)
    else $error("read result carries a line action");

  a_enable_width: assert property (@(posedge clk) disable iff (!rst_n)
    (regs_r[IDX_ENABLE] & ~SRC_MASK) == '0)
    else $error("enable word has bits beyond the sources");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !adv |=> s0_valid_r && $stable(s0_data_r))
    else $error("input register changed while blocked");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench
  import irqc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t result;
  } plan_row_t;

  localparam int PHASE_ITEMS = 140;
  localparam int LONG_HOLD   = 80;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [WIN_W-1:0] cfg_window_bytes;

  logic      pin_on;
  out_item_t pin_val;

  logic [DATA_W-1:0] ctrl_words [DEF_REG_WORDS];
  logic [WIN_W-1:0]  window_size;
  out_item_t         pending_results [$];
  plan_row_t         plan [$];
  int unsigned       fail_count;
  bit                steady_send;
  bit                steady_take;
  bit                hold_req;

  irq_fiq_interrupt_controller_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_bytes (cfg_window_bytes)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic in_item_t mk(func_t f, logic [OFF_W-1:0] off, logic [DATA_W-1:0] d,
                                  logic [SRC_W-1:0] s);
    in_item_t it;
    it.func       = f;
    it.reg_offset = off;
    it.write_word = d;
    it.source_num = s;
    return it;
  endfunction

  function automatic out_item_t res(logic [DATA_W-1:0] rd, action_t a, logic [1:0] ln);
    out_item_t r;
    r.read_word   = rd;
    r.line_action = a;
    r.cpu_line    = ln;
    return r;
  endfunction

  function automatic out_item_t run_controller(in_item_t it);
    out_item_t         r;
    logic [WORD_W-1:0] widx;
    logic [OFF_W-1:0]  aligned;
    logic [DATA_W-1:0] src_bit;
    logic [1:0]        ln;
    int                sidx;
    r = res('0, ACT_NONE, LINE_IRQ);
    widx = it.reg_offset[OFF_W-1:2];
    aligned = {it.reg_offset[OFF_W-1:2], 2'b00};
    if (it.func == FUNC_READ || it.func == FUNC_WRITE) begin
      if ({1'b0, it.reg_offset} < window_size && int'(widx) < DEF_REG_WORDS) begin
        if (it.func == FUNC_READ) begin
          r.read_word = ctrl_words[widx];
        end else if (aligned == OFF_ENABLE) begin
          ctrl_words[IDX_ENABLE] |= it.write_word & SRC_MASK;
        end else if (aligned == OFF_DISABLE) begin
          ctrl_words[IDX_ENABLE] &= ~(it.write_word & SRC_MASK);
        end else begin
          ctrl_words[widx] = it.write_word;
        end
      end
    end else if (it.source_num < NUM_SOURCES) begin
      src_bit = 32'd1 << it.source_num;
      ln = (it.source_num != SRC_IRQ_ONLY && ctrl_words[IDX_MODE][it.source_num]) ?
           LINE_FIQ : LINE_IRQ;
      sidx = (ln == LINE_FIQ) ? IDX_FIQ_STATUS : IDX_IRQ_STATUS;
      if (it.func == FUNC_RAISE) begin
        ctrl_words[IDX_RAW_STATUS] |= src_bit;
        if ((ctrl_words[IDX_ENABLE] & src_bit) != '0) begin
          ctrl_words[sidx] |= src_bit;
          r.line_action = ACT_RAISE;
          r.cpu_line = ln;
        end
      end else begin
        ctrl_words[IDX_RAW_STATUS] &= ~src_bit;
        ctrl_words[sidx] &= ~src_bit;
        r.line_action = ACT_LOWER;
        r.cpu_line = ln;
      end
    end
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t          it;
    int unsigned       pick;
    logic [OFF_W-1:0]  hot [6];
    hot = '{6'h00, 6'h04, 6'h08, 6'h0C, 6'h14, 6'h18};
    pick = $urandom_range(0, 99);
    it.func = (pick < 30) ? FUNC_READ : (pick < 55) ? FUNC_WRITE :
              (pick < 80) ? FUNC_RAISE : FUNC_CLEAR;
    if ($urandom_range(0, 1) == 0) begin
      it.reg_offset = hot[$urandom_range(0, 5)] | OFF_W'($urandom_range(0, 3));
    end else begin
      it.reg_offset = OFF_W'($urandom_range(0, 63));
    end
    it.write_word = $urandom;
    it.source_num = ($urandom_range(0, 99) < 85) ? SRC_W'($urandom_range(0, 9)) :
                    SRC_W'($urandom_range(10, 15));
    return it;
  endfunction

  function automatic int unsigned idle_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      foreach (ctrl_words[i]) ctrl_words[i] = '0;
      window_size = WINDOW_RESET;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_size = cfg_window_bytes;
      end
      if (in_valid && !in_stall) begin
        want = run_controller(in_data);
        pending_results.push_back(pin_on ? pin_val : want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got.read_word !== want.read_word) begin
            fail_count++;
            $display("%0t: read_word expected %h actual %h", $time, want.read_word,
                     got.read_word);
          end
          if (got.line_action !== want.line_action) begin
            fail_count++;
            $display("%0t: line_action expected %0d actual %0d", $time, want.line_action,
                     got.line_action);
          end
          if (got.cpu_line !== want.cpu_line) begin
            fail_count++;
            $display("%0t: cpu_line expected %0d actual %0d", $time, want.cpu_line,
                     got.cpu_line);
          end
        end
      end
    end
  end

  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = idle_gap(steady_take);
      if (hold_req) begin
        hold = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(in_item_t it, bit pinned, out_item_t pv);
    int unsigned gap;
    gap = idle_gap(steady_send);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    pin_on   <= pinned;
    pin_val  <= pv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    @(negedge clk);
  endtask

  task automatic set_window(logic [WIN_W-1:0] w);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_window_bytes <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_row(in_item_t it, bit pinned, out_item_t r);
    plan_row_t row;
    row.item   = it;
    row.pinned = pinned;
    row.result = r;
    plan.push_back(row);
  endtask

  initial begin
    out_item_t        quiet;
    logic [WIN_W-1:0] windows [7];
    windows     = '{7'd0, 7'd1, 7'd63, 7'd64, 7'd36, 7'd12, 7'd64};
    quiet       = res('0, ACT_NONE, LINE_IRQ);
    fail_count  = 0;
    steady_send = 1'b0;
    steady_take = 1'b0;
    hold_req    = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    pin_on           = 1'b0;
    pin_val          = '0;
    cfg_valid        = 1'b0;
    cfg_window_bytes = '0;

    plan_row(mk(FUNC_READ, 6'h00, 32'h0, 4'd0), 1, quiet);
    plan_row(mk(FUNC_READ, 6'h3F, 32'hFFFF_FFFF, 4'd15), 1, quiet);
    plan_row(mk(FUNC_WRITE, 6'h3C, 32'hFFFF_FFFF, 4'd15), 1, quiet);
    plan_row(mk(FUNC_READ, 6'h3F, 32'h0, 4'd0), 1, res(32'hFFFF_FFFF, ACT_NONE, LINE_IRQ));
    plan_row(mk(FUNC_WRITE, OFF_ENABLE, 32'hFFFF_FFFF, 4'd0), 1, quiet);
    plan_row(mk(FUNC_READ, 6'h0B, 32'h0, 4'd0), 1, res(SRC_MASK, ACT_NONE, LINE_IRQ));
    plan_row(mk(FUNC_WRITE, 6'h0D, 32'h0000_0001, 4'd0), 1, quiet);
    plan_row(mk(FUNC_WRITE, 6'h14, 32'h0000_02AA, 4'd0), 1, quiet);
    plan_row(mk(FUNC_RAISE, 6'h00, 32'h0, 4'd0), 1, quiet);
    plan_row(mk(FUNC_RAISE, 6'h00, 32'h0, 4'd1), 1, res('0, ACT_RAISE, LINE_FIQ));
    plan_row(mk(FUNC_RAISE, 6'h00, 32'h0, 4'd2), 1, res('0, ACT_RAISE, LINE_IRQ));
    plan_row(mk(FUNC_RAISE, 6'h00, 32'h0, 4'd9), 1, res('0, ACT_RAISE, LINE_IRQ));
    plan_row(mk(FUNC_RAISE, 6'h00, 32'h0, 4'd15), 1, quiet);
    plan_row(mk(FUNC_CLEAR, 6'h00, 32'h0, 4'd10), 1, quiet);
    plan_row(mk(FUNC_READ, 6'h04, 32'h0, 4'd0), 0, quiet);
    plan_row(mk(FUNC_READ, 6'h18, 32'h0, 4'd0), 0, quiet);
    plan_row(mk(FUNC_READ, 6'h00, 32'h0, 4'd0), 0, quiet);
    plan_row(mk(FUNC_CLEAR, 6'h00, 32'h0, 4'd0), 1, res('0, ACT_LOWER, LINE_IRQ));
    plan_row(mk(FUNC_CLEAR, 6'h00, 32'h0, 4'd1), 1, res('0, ACT_LOWER, LINE_FIQ));
    plan_row(mk(FUNC_CLEAR, 6'h00, 32'h0, 4'd9), 1, res('0, ACT_LOWER, LINE_IRQ));
    plan_row(mk(FUNC_WRITE, 6'h10, 32'h1234_5678, 4'd0), 1, quiet);
    plan_row(mk(FUNC_READ, 6'h10, 32'h0, 4'd0), 1, res(32'h1234_5678, ACT_NONE, LINE_IRQ));
    plan_row(mk(FUNC_WRITE, OFF_DISABLE, 32'hFFFF_FFFF, 4'd0), 1, quiet);
    plan_row(mk(FUNC_RAISE, 6'h00, 32'h0, 4'd3), 0, quiet);
    plan_row(mk(FUNC_READ, OFF_ENABLE, 32'h0, 4'd0), 0, quiet);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_window(WINDOW_RESET);
    foreach (plan[i]) send_item(plan[i].item, plan[i].pinned, plan[i].result);

    foreach (windows[p]) begin
      set_window(windows[p]);
      steady_send = (p == 2);
      steady_take = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 30) hold_req = 1'b1;
        if (p == 4 && n == 70) drain_results();
        send_item(random_item(), 1'b0, quiet);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("irq_fiq_interrupt_controller_unit test passed");
    end else begin
      $display("irq_fiq_interrupt_controller_unit test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("irq_fiq_interrupt_controller_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/irqc_pkg.sv
rtl/irq_fiq_interrupt_controller_unit.sv
tb/testbench.sv
